@@ hw/rtl/wmm_pkg.sv @@
// ----------------------------------------------------------------------------
// wmm_pkg
// Shared types, codes and the microcode table of the Winograd matrix
// multiply core.
// ----------------------------------------------------------------------------
package wmm_pkg;

    // defaults for the top-level parameters
    localparam int MAX_DIM_DEF    = 8;
    localparam int VALUE_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_FIELD_W = 3;
    localparam int ELEM_W      = 16;
    localparam int OUT_W       = 40;
    localparam int STEP_W      = 5;

    // command codes
    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    // microprogram step addresses
    localparam logic [STEP_W-1:0] STEP_ROW_INIT  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_ROW_RD0   = 5'd1;
    localparam logic [STEP_W-1:0] STEP_ROW_RD1   = 5'd2;
    localparam logic [STEP_W-1:0] STEP_ROW_LAT   = 5'd3;
    localparam logic [STEP_W-1:0] STEP_ROW_MUL   = 5'd4;
    localparam logic [STEP_W-1:0] STEP_ROW_ACC   = 5'd5;
    localparam logic [STEP_W-1:0] STEP_ROW_STORE = 5'd6;
    localparam logic [STEP_W-1:0] STEP_COL_INIT  = 5'd7;
    localparam logic [STEP_W-1:0] STEP_COL_RD0   = 5'd8;
    localparam logic [STEP_W-1:0] STEP_COL_RD1   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_COL_LAT   = 5'd10;
    localparam logic [STEP_W-1:0] STEP_COL_MUL   = 5'd11;
    localparam logic [STEP_W-1:0] STEP_COL_ACC   = 5'd12;
    localparam logic [STEP_W-1:0] STEP_COL_STORE = 5'd13;
    localparam logic [STEP_W-1:0] STEP_ENT_INIT  = 5'd14;
    localparam logic [STEP_W-1:0] STEP_ENT_RD0   = 5'd15;
    localparam logic [STEP_W-1:0] STEP_ENT_RD1   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_ENT_LAT   = 5'd17;
    localparam logic [STEP_W-1:0] STEP_ENT_MUL   = 5'd18;
    localparam logic [STEP_W-1:0] STEP_ENT_ACC   = 5'd19;
    localparam logic [STEP_W-1:0] STEP_ODD_RD    = 5'd20;
    localparam logic [STEP_W-1:0] STEP_ODD_LAT   = 5'd21;
    localparam logic [STEP_W-1:0] STEP_ODD_MUL   = 5'd22;
    localparam logic [STEP_W-1:0] STEP_ODD_ACC   = 5'd23;
    localparam logic [STEP_W-1:0] STEP_EMIT      = 5'd24;

    // command word
    typedef struct packed {
        logic [1:0]             func;
        logic [IDX_FIELD_W-1:0] elem_row;
        logic [IDX_FIELD_W-1:0] elem_col;
        logic signed [ELEM_W-1:0] elem_value;
    } t_in;

    // result word
    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  out_row;
        logic [IDX_FIELD_W-1:0]  out_col;
        logic signed [OUT_W-1:0] out_value;
        logic                    last;
    } t_out;

    // operand register source
    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_A    = 2'd1,
        SRC_B    = 2'd2,
        SRC_SUM  = 2'd3
    } t_src;

    // store index select: pair base, pair base plus one, last inner index
    typedef enum logic [1:0] {
        SEL_K    = 2'd0,
        SEL_K1   = 2'd1,
        SEL_LAST = 2'd2
    } t_asel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_CLR  = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_FACT = 2'd3
    } t_acc_op;

    typedef enum logic [1:0] {
        K_HOLD = 2'd0,
        K_CLR  = 2'd1,
        K_ADV  = 2'd2
    } t_k_op;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_ROW  = 2'd1,
        CNT_COL  = 2'd2,
        CNT_ENT  = 2'd3
    } t_cnt_op;

    typedef enum logic [1:0] {
        FW_NONE = 2'd0,
        FW_ROW  = 2'd1,
        FW_COL  = 2'd2
    } t_fw;

    typedef enum logic [2:0] {
        JC_NONE       = 3'd0,
        JC_NO_PAIRS   = 3'd1,
        JC_MORE_PAIRS = 3'd2,
        JC_M_EVEN     = 3'd3,
        JC_I_MORE     = 3'd4,
        JC_J_MORE     = 3'd5,
        JC_ENT_MORE   = 3'd6
    } t_jc;

    // one control word
    typedef struct packed {
        t_src              x_src;
        t_src              y_src;
        t_asel             a_sel;
        t_asel             b_sel;
        logic              mul;
        t_acc_op           acc_op;
        t_k_op             k_op;
        t_cnt_op           cnt_op;
        t_fw               fw;
        logic              emit;
        logic              fin;
        t_jc               jc;
        logic [STEP_W-1:0] target;
    } t_uop;

    // datapath status used by the jump logic
    typedef struct packed {
        logic no_pairs;
        logic more_pairs;
        logic m_even;
        logic i_more;
        logic j_more;
    } t_flags;

    // microprogram rom
    function automatic t_uop f_ucode(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '0;
        unique case (step)
            // row factors: sum of a[i][k] * a[i][k+1] over pairs
            STEP_ROW_INIT: begin
                u.acc_op = ACC_CLR;
                u.k_op   = K_CLR;
                u.jc     = JC_NO_PAIRS;
                u.target = STEP_ROW_STORE;
            end
            STEP_ROW_RD0: begin
                u.a_sel = SEL_K;
            end
            STEP_ROW_RD1: begin
                u.a_sel = SEL_K1;
                u.x_src = SRC_A;
            end
            STEP_ROW_LAT: begin
                u.y_src = SRC_A;
            end
            STEP_ROW_MUL: begin
                u.mul = 1'b1;
            end
            STEP_ROW_ACC: begin
                u.acc_op = ACC_ADD;
                u.k_op   = K_ADV;
                u.jc     = JC_MORE_PAIRS;
                u.target = STEP_ROW_RD0;
            end
            STEP_ROW_STORE: begin
                u.fw     = FW_ROW;
                u.cnt_op = CNT_ROW;
                u.jc     = JC_I_MORE;
                u.target = STEP_ROW_INIT;
            end
            // column factors: sum of b[k][j] * b[k+1][j] over pairs
            STEP_COL_INIT: begin
                u.acc_op = ACC_CLR;
                u.k_op   = K_CLR;
                u.jc     = JC_NO_PAIRS;
                u.target = STEP_COL_STORE;
            end
            STEP_COL_RD0: begin
                u.b_sel = SEL_K;
            end
            STEP_COL_RD1: begin
                u.b_sel = SEL_K1;
                u.x_src = SRC_B;
            end
            STEP_COL_LAT: begin
                u.y_src = SRC_B;
            end
            STEP_COL_MUL: begin
                u.mul = 1'b1;
            end
            STEP_COL_ACC: begin
                u.acc_op = ACC_ADD;
                u.k_op   = K_ADV;
                u.jc     = JC_MORE_PAIRS;
                u.target = STEP_COL_RD0;
            end
            STEP_COL_STORE: begin
                u.fw     = FW_COL;
                u.cnt_op = CNT_COL;
                u.jc     = JC_J_MORE;
                u.target = STEP_COL_INIT;
            end
            // entries: pair terms minus both factors
            STEP_ENT_INIT: begin
                u.acc_op = ACC_FACT;
                u.k_op   = K_CLR;
                u.jc     = JC_NO_PAIRS;
                u.target = STEP_ODD_RD;
            end
            STEP_ENT_RD0: begin
                u.a_sel = SEL_K;
                u.b_sel = SEL_K1;
            end
            STEP_ENT_RD1: begin
                u.a_sel = SEL_K1;
                u.b_sel = SEL_K;
                u.x_src = SRC_SUM;
            end
            STEP_ENT_LAT: begin
                u.y_src = SRC_SUM;
            end
            STEP_ENT_MUL: begin
                u.mul = 1'b1;
            end
            STEP_ENT_ACC: begin
                u.acc_op = ACC_ADD;
                u.k_op   = K_ADV;
                u.jc     = JC_MORE_PAIRS;
                u.target = STEP_ENT_RD0;
            end
            // odd inner length: last column of a times last row of b
            STEP_ODD_RD: begin
                u.a_sel  = SEL_LAST;
                u.b_sel  = SEL_LAST;
                u.jc     = JC_M_EVEN;
                u.target = STEP_EMIT;
            end
            STEP_ODD_LAT: begin
                u.x_src = SRC_A;
                u.y_src = SRC_B;
            end
            STEP_ODD_MUL: begin
                u.mul = 1'b1;
            end
            STEP_ODD_ACC: begin
                u.acc_op = ACC_ADD;
            end
            STEP_EMIT: begin
                u.emit   = 1'b1;
                u.cnt_op = CNT_ENT;
                u.fin    = 1'b1;
                u.jc     = JC_ENT_MORE;
                u.target = STEP_ENT_INIT;
            end
            default: begin
                u.fin = 1'b1;
            end
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/wmm_ram.sv @@
// ----------------------------------------------------------------------------
// wmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/wmm_useq.sv @@
// ----------------------------------------------------------------------------
// wmm_useq
// Microcode sequencer: step counter, control rom and conditional jumps.
// ----------------------------------------------------------------------------
module wmm_useq import wmm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_go,
    input  t_flags i_flags,
    output t_uop   o_uop,
    output logic   o_busy
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              r_busy;
    logic              n_busy;
    t_uop              uop;
    logic              taken;

    // current control word; the output masks it to a no-op while idle
    always_comb begin
        uop = f_ucode(r_step);
    end

    // jump condition
    always_comb begin
        unique case (uop.jc)
            JC_NONE:       taken = 1'b0;
            JC_NO_PAIRS:   taken = i_flags.no_pairs;
            JC_MORE_PAIRS: taken = i_flags.more_pairs;
            JC_M_EVEN:     taken = i_flags.m_even;
            JC_I_MORE:     taken = i_flags.i_more;
            JC_J_MORE:     taken = i_flags.j_more;
            JC_ENT_MORE:   taken = i_flags.i_more || i_flags.j_more;
            default:       taken = 1'b0;
        endcase
    end

    // next step and run flag
    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (r_busy) begin
            n_step = taken ? uop.target : r_step + STEP_W'(1);
            if (uop.fin && !taken) begin
                n_busy = 1'b0;
            end
        end else if (i_go) begin
            n_step = STEP_ROW_INIT;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_ROW_INIT;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

    assign o_uop  = r_busy ? uop : t_uop'('0);
    assign o_busy = r_busy;

endmodule

@@ hw/rtl/wmm_dpath.sv @@
// ----------------------------------------------------------------------------
// wmm_dpath
// Datapath: element stores, loop counters, operand registers, one
// multiplier, accumulator, factor registers and the result register.
// ----------------------------------------------------------------------------
module wmm_dpath import wmm_pkg::*; #(
    parameter int  MAX_DIM    = MAX_DIM_DEF,
    parameter int  VALUE_BITS = VALUE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_DIM)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  t_in              i_cmd,
    input  logic             i_go,
    input  t_uop             i_uop,
    input  logic [IDX_W-1:0] i_rows_last,
    input  logic [IDX_W-1:0] i_inner_last,
    input  logic [IDX_W-1:0] i_cols_last,
    output t_flags           o_flags,
    output logic             o_strobe,
    output t_out             o_result
);

    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int OPND_W = VALUE_BITS + 1;
    localparam int PROD_W = 2 * OPND_W;
    localparam logic [IDX_FIELD_W:0] DIM_LIM = (IDX_FIELD_W + 1)'(MAX_DIM);

    logic                     we_a;
    logic                     we_b;
    logic                     in_range;
    logic [ADDR_W-1:0]        waddr;
    logic [VALUE_BITS-1:0]    wdata;
    logic [ADDR_W-1:0]        raddr_a;
    logic [ADDR_W-1:0]        raddr_b;
    logic [VALUE_BITS-1:0]    rdata_a;
    logic [VALUE_BITS-1:0]    rdata_b;
    logic [IDX_W-1:0]         a_col;
    logic [IDX_W-1:0]         b_row;

    logic [IDX_W-1:0]         r_i;
    logic [IDX_W-1:0]         n_i;
    logic [IDX_W-1:0]         r_j;
    logic [IDX_W-1:0]         n_j;
    logic [IDX_W-1:0]         r_k;
    logic [IDX_W-1:0]         n_k;

    logic signed [OPND_W-1:0] a_val;
    logic signed [OPND_W-1:0] b_val;
    logic signed [OPND_W-1:0] sum_val;
    logic signed [OPND_W-1:0] r_x;
    logic signed [OPND_W-1:0] r_y;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OUT_W-1:0]  r_acc;
    logic signed [OUT_W-1:0]  n_acc;
    logic signed [OUT_W-1:0]  r_rowf [MAX_DIM];
    logic signed [OUT_W-1:0]  r_colf [MAX_DIM];

    logic                     r_strobe;
    t_out                     r_result;
    t_flags                   flags;

    // load decode, out-of-range indexes are dropped
    assign in_range = ({1'b0, i_cmd.elem_row} < DIM_LIM) && ({1'b0, i_cmd.elem_col} < DIM_LIM);
    assign we_a     = i_load && (i_cmd.func == FUNC_LOAD_A) && in_range;
    assign we_b     = i_load && (i_cmd.func == FUNC_LOAD_B) && in_range;
    assign waddr    = {i_cmd.elem_row[IDX_W-1:0], i_cmd.elem_col[IDX_W-1:0]};
    assign wdata    = VALUE_BITS'($unsigned(i_cmd.elem_value));

    // store index select
    always_comb begin
        case (i_uop.a_sel)
            SEL_K:    a_col = r_k;
            SEL_K1:   a_col = r_k + IDX_W'(1);
            SEL_LAST: a_col = i_inner_last;
            default:  a_col = r_k;
        endcase
        case (i_uop.b_sel)
            SEL_K:    b_row = r_k;
            SEL_K1:   b_row = r_k + IDX_W'(1);
            SEL_LAST: b_row = i_inner_last;
            default:  b_row = r_k;
        endcase
    end

    assign raddr_a = {r_i, a_col};
    assign raddr_b = {b_row, r_j};

    // left matrix store, row-major
    wmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_left (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    // right matrix store, row-major
    wmm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_right (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // operands, one bit wider to hold a pair sum
    assign a_val   = OPND_W'($signed(rdata_a));
    assign b_val   = OPND_W'($signed(rdata_b));
    assign sum_val = a_val + b_val;

    // operand registers and the shared multiplier
    always_ff @(posedge i_clk) begin
        case (i_uop.x_src)
            SRC_A:   r_x <= a_val;
            SRC_B:   r_x <= b_val;
            SRC_SUM: r_x <= sum_val;
            default: r_x <= r_x;
        endcase
        case (i_uop.y_src)
            SRC_A:   r_y <= a_val;
            SRC_B:   r_y <= b_val;
            SRC_SUM: r_y <= sum_val;
            default: r_y <= r_y;
        endcase
        if (i_uop.mul) begin
            r_prod <= r_x * r_y;
        end
    end

    // accumulator, wraps modulo the result width
    always_comb begin
        case (i_uop.acc_op)
            ACC_CLR:  n_acc = '0;
            ACC_ADD:  n_acc = r_acc + OUT_W'(r_prod);
            ACC_FACT: n_acc = -r_rowf[r_i] - r_colf[r_j];
            default:  n_acc = r_acc;
        endcase
    end

    // factor registers and accumulator
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (i_uop.fw == FW_ROW) begin
            r_rowf[r_i] <= r_acc;
        end
        if (i_uop.fw == FW_COL) begin
            r_colf[r_j] <= r_acc;
        end
    end

    // loop status
    assign flags.no_pairs   = (i_inner_last == '0);
    assign flags.more_pairs = ({1'b0, r_k} + (IDX_W + 1)'(3)) <= {1'b0, i_inner_last};
    assign flags.m_even     = i_inner_last[0];
    assign flags.i_more     = (r_i != i_rows_last);
    assign flags.j_more     = (r_j != i_cols_last);

    // loop counters
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        case (i_uop.k_op)
            K_CLR:   n_k = '0;
            K_ADV:   n_k = r_k + IDX_W'(2);
            default: n_k = r_k;
        endcase
        case (i_uop.cnt_op)
            CNT_ROW: n_i = flags.i_more ? r_i + IDX_W'(1) : '0;
            CNT_COL: n_j = flags.j_more ? r_j + IDX_W'(1) : '0;
            CNT_ENT: begin
                if (flags.j_more) begin
                    n_j = r_j + IDX_W'(1);
                end else begin
                    n_j = '0;
                    n_i = flags.i_more ? r_i + IDX_W'(1) : '0;
                end
            end
            default: begin
                n_i = r_i;
                n_j = r_j;
            end
        endcase
        if (i_go) begin
            n_i = '0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_i      <= n_i;
            r_j      <= n_j;
            r_k      <= n_k;
            r_strobe <= i_uop.emit;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_uop.emit) begin
            r_result.out_row   <= IDX_FIELD_W'(r_i);
            r_result.out_col   <= IDX_FIELD_W'(r_j);
            r_result.out_value <= r_acc;
            r_result.last      <= !flags.i_more && !flags.j_more;
        end
    end

    assign o_flags  = flags;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

@@ hw/rtl/winograd_matrix_multiply_core.sv @@
// ----------------------------------------------------------------------------
// winograd_matrix_multiply_core
// Loads two matrices element by element and, on a compute command, emits
// their product in row-major order using Winograd's pair products.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake                    word
// -------  ---  ---------------------------  --------------------------------
// command  in   start && !busy               i_cmd   (t_in)
// config   in   i_cfg_valid && o_cfg_ready   i_cfg_index, i_cfg_data
// result   out  o_strobe, one cycle each     o_result (t_out)
//
// Loads may follow back to back and busy stays low. A compute holds busy
// while the microprogram walks the stores through one shared multiplier.
// Results leave in the cycle after their emit step and cannot be held off.
// Synchronous active-low reset; the stores are not cleared.
//
module winograd_matrix_multiply_core import wmm_pkg::*; #(
    parameter int  MAX_DIM    = MAX_DIM_DEF,
    parameter int  VALUE_BITS = VALUE_BITS_DEF,
    localparam int IDX_W      = $clog2(MAX_DIM)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_in                  i_cmd,
    output logic                 busy,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_cfg_ready,
    output logic                 o_strobe,
    output t_out                 o_result
);

    logic [IDX_W-1:0] r_rows_last;
    logic [IDX_W-1:0] r_inner_last;
    logic [IDX_W-1:0] r_cols_last;
    logic             accept;
    logic             go;
    t_uop             uop;
    t_flags           flags;

    // dimension register to last index, clamped to 1..MAX_DIM
    function automatic logic [IDX_W-1:0] f_last(input logic [CFG_W-1:0] v);
        logic [IDX_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(v - CFG_W'(1));
        end
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_last  <= IDX_W'(MAX_DIM - 1);
            r_inner_last <= IDX_W'(MAX_DIM - 1);
            r_cols_last  <= IDX_W'(MAX_DIM - 1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_last  <= f_last(i_cfg_data);
                CFG_INNER_LEN: r_inner_last <= f_last(i_cfg_data);
                CFG_COLS_B:    r_cols_last  <= f_last(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // command accept
    assign accept = start && !busy;
    assign go     = accept && (i_cmd.func == FUNC_COMPUTE);

    wmm_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_flags (flags),
        .o_uop   (uop),
        .o_busy  (busy)
    );

    wmm_dpath #(
        .MAX_DIM    (MAX_DIM),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_cmd        (i_cmd),
        .i_go         (go),
        .i_uop        (uop),
        .i_rows_last  (r_rows_last),
        .i_inner_last (r_inner_last),
        .i_cols_last  (r_cols_last),
        .o_flags      (flags),
        .o_strobe     (o_strobe),
        .o_result     (o_result)
    );

    // results come only out of a running compute
    a_strobe_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result word without a running compute");

    // the final word ends the compute
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> !busy)
        else $error("busy still high after the final word");

    // words before the final one leave the compute running
    a_mid_keeps_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |-> busy)
        else $error("compute ended before the final word");

    // only a compute command starts a run
    a_run_from_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && (i_cmd.func == FUNC_COMPUTE)))
        else $error("busy rose without a compute command");

endmodule
